FILE: src/bhi_pkg.sv
// Shared widths, codes, types and digit arithmetic of the bucketed hash insert block.
package bhi_pkg;

	localparam int KEY_W      = 24;
	localparam int PAY_W      = 32;
	localparam int STAT_W     = 2;
	localparam int BKT_OUT_W  = 10;
	localparam int SLOT_OUT_W = 3;
	localparam int MODE_W     = 2;
	localparam int CFG_W      = 11;
	localparam int PADDR_W    = 4;
	localparam int PDATA_W    = 32;

	localparam int SLOTS_PER_BUCKET_DEF = 8;
	localparam int MAX_BUCKETS_DEF      = 1024;

	// Remainder unit operand sizing
	localparam int DIV_W  = KEY_W;
	localparam int LEN_W  = $clog2(DIV_W + 1);
	localparam int BIT_W  = $clog2(DIV_W);

	// Digit converter and hash sums
	localparam int BCD_DIGITS = 8;
	localparam int OCT_DIGITS = 7;
	localparam int FOLD_W     = 12;
	localparam int OCT_W      = 22;

	// Register reset values
	localparam logic [MODE_W-1:0] HASH_MODE_RST = 2'd2;
	localparam logic [CFG_W-1:0]  PRIME_RST     = 11'd1021;
	localparam logic [CFG_W-1:0]  BUCKETS_RST   = 11'd1024;

	// Register indexes
	localparam logic [1:0] REG_HASH_MODE = 2'd0;
	localparam logic [1:0] REG_PRIME     = 2'd1;
	localparam logic [1:0] REG_BUCKETS   = 2'd2;

	// Hash modes; any other code selects the octal reading
	localparam logic [MODE_W-1:0] MODE_FOLD  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_PRIME = 2'd1;

	typedef enum logic [STAT_W-1:0] {
		STAT_STORED   = 2'd0,
		STAT_FULL     = 2'd1,
		STAT_ZERO_KEY = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_BCD,
		ST_HASH,
		ST_REDUCE,
		ST_RD,
		ST_CHK,
		ST_OUT
	} state_t;

	typedef logic [BCD_DIGITS-1:0][3:0] bcd_t;

	typedef struct packed {
		logic              start;
		logic [LEN_W-1:0]  len;
		logic [DIV_W-1:0]  dividend;
		logic [CFG_W-1:0]  divisor;
	} rem_req_t;

	typedef struct packed {
		logic              done;
		logic [CFG_W-1:0]  rem;
	} rem_rsp_t;

	// Digit fold: top group in order, middle group,
	// bottom pair swapped, all added.
	function automatic logic [FOLD_W-1:0] fold_sum(input bcd_t d);
		logic [FOLD_W-1:0] s;
		s = FOLD_W'(d[7]) * FOLD_W'(100) + FOLD_W'(d[6]) * FOLD_W'(10) + FOLD_W'(d[5])
			+ FOLD_W'(d[4]) * FOLD_W'(110) + FOLD_W'(d[3]) * FOLD_W'(10) + FOLD_W'(d[2])
			+ FOLD_W'(d[1]) + FOLD_W'(d[0]) * FOLD_W'(10);
		return s;
	endfunction

	// Seven low decimal digits weighted by powers of eight.
	function automatic logic [OCT_W-1:0] octal_acc(input bcd_t d);
		logic [OCT_W-1:0] s;
		s = '0;
		for (int i = 0; i < OCT_DIGITS; i++) begin
			s = s + (OCT_W'(d[i]) << (3 * i));
		end
		return s;
	endfunction

endpackage

FILE: src/bhi_if.sv
// Valid/ready channel interfaces for records in and insert results out.
interface bhi_rec_if import bhi_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [KEY_W-1:0] record_key;
	logic [PAY_W-1:0] record_payload;

	modport source (output valid, output record_key, output record_payload, input ready);
	modport sink   (input valid, input record_key, input record_payload, output ready);
endinterface

interface bhi_res_if import bhi_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [STAT_W-1:0]     status;
	logic [BKT_OUT_W-1:0]  home_bucket;
	logic [BKT_OUT_W-1:0]  placed_bucket;
	logic [SLOT_OUT_W-1:0] placed_slot;
	logic                  overflowed;

	modport source (output valid, output status, output home_bucket, output placed_bucket,
		output placed_slot, output overflowed, input ready);
	modport sink   (input valid, input status, input home_bucket, input placed_bucket,
		input placed_slot, input overflowed, output ready);
endinterface

FILE: src/bhi_rem.sv
// Shared restoring remainder unit: one dividend bit per cycle.
module bhi_rem import bhi_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  rem_req_t req,
	output rem_rsp_t rsp
);

	logic [DIV_W-1:0] dvd_q;
	logic [CFG_W-1:0] dvs_q;
	logic [CFG_W-1:0] r_q;
	logic [BIT_W-1:0] bit_q;
	logic             busy_q;
	logic             done_q;
	logic [CFG_W:0]   trial;
	logic [CFG_W-1:0] r_next;

	always_comb begin
		trial = {r_q, dvd_q[bit_q]};
		if (trial >= {1'b0, dvs_q}) begin
			r_next = CFG_W'(trial - {1'b0, dvs_q});
		end else begin
			r_next = CFG_W'(trial);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
			bit_q <= BIT_W'(req.len - LEN_W'(1));
			r_q   <= '0;
		end else if (busy_q) begin
			r_q <= r_next;
			if (bit_q != '0) begin
				bit_q <= bit_q - BIT_W'(1);
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem  = r_q;

endmodule

FILE: src/bhi_bcd.sv
// Binary to decimal digit converter, shift-and-add-three, one key bit per cycle.
module bhi_bcd import bhi_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [KEY_W-1:0] key,
	output logic             done,
	output bcd_t             digits
);

	localparam int CNT_W = $clog2(KEY_W);

	logic [KEY_W-1:0] bin_q;
	bcd_t             bcd_q;
	bcd_t             adj;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	always_comb begin
		for (int i = 0; i < BCD_DIGITS; i++) begin
			adj[i] = (bcd_q[i] >= 4'd5) ? bcd_q[i] + 4'd3 : bcd_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= key;
			bcd_q <= '0;
			cnt_q <= CNT_W'(KEY_W - 1);
		end else if (busy_q) begin
			{bcd_q, bin_q} <= {adj, bin_q} << 1;
			if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	assign done   = done_q;
	assign digits = bcd_q;

endmodule

FILE: src/bhi_fill.sv
// Per-bucket fill count memory, one write and one registered read port.
module bhi_fill #(
	parameter int DEPTH  = 1024,
	parameter int ADDR_W = 10,
	parameter int DATA_W = 4
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

FILE: src/bhi_store.sv
// Key and payload slot storage, addressed by bucket and slot.
module bhi_store import bhi_pkg::*; #(
	parameter int SLOTS_PER_BUCKET = SLOTS_PER_BUCKET_DEF,
	parameter int MAX_BUCKETS      = MAX_BUCKETS_DEF,
	parameter int BKT_W            = 10,
	parameter int FILL_W           = 4
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [BKT_W-1:0]  bkt,
	input  logic [FILL_W-1:0] slot,
	input  logic [KEY_W-1:0]  key,
	input  logic [PAY_W-1:0]  payload
);

	localparam int DEPTH = MAX_BUCKETS * SLOTS_PER_BUCKET;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [KEY_W-1:0] key_mem [DEPTH];
	logic [PAY_W-1:0] pay_mem [DEPTH];
	logic [IDX_W-1:0] idx;

	assign idx = IDX_W'(bkt) * IDX_W'(SLOTS_PER_BUCKET) + IDX_W'(slot);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem[idx] <= key;
			pay_mem[idx] <= payload;
		end
	end

endmodule

FILE: src/bucketed_hash_insert.sv
// Top level of the bucketed hash insert block: registers, sequencer and datapath.
//
//  channel  | dir | handshake         | payload
//  ---------+-----+-------------------+---------------------------------------------
//  rec      | in  | valid/ready       | record_key[23:0], record_payload[31:0]
//  res      | out | valid/ready       | status, home_bucket, placed_bucket,
//           |     |                   | placed_slot, overflowed
//  apb      | in  | psel/penable      | paddr[3:0], pwdata/prdata[31:0], pready = 1
//
//  One record at a time. After the accept, the key goes through the digit converter
//  (fold and octal modes) and then through the shared remainder unit, one dividend
//  bit per cycle, with a second remainder pass when the home must be reduced by the
//  bucket count. Each bucket visited is probed by a read and then a check, and the
//  outcome then goes into the result register.
//  A zero key goes from the accept straight to ST_OUT and then into the result
//  register; rec.ready is back in the same cycle that res.valid rises.
//  After reset a clearing pass zeroes the fill memory, one bucket at a time, with
//  rec.ready low; register writes are taken throughout.
//  A result waiting on res.ready does not block the next accept; the sequencer only
//  holds in ST_OUT when the previous result has still not been taken.
module bucketed_hash_insert import bhi_pkg::*; #(
	parameter int SLOTS_PER_BUCKET = SLOTS_PER_BUCKET_DEF,
	parameter int MAX_BUCKETS      = MAX_BUCKETS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	bhi_rec_if.sink            rec,
	bhi_res_if.source          res,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	localparam int BKT_W  = $clog2(MAX_BUCKETS);
	localparam int FILL_W = $clog2(SLOTS_PER_BUCKET + 1);
	localparam int MAXB_W = $clog2(MAX_BUCKETS + 1);
	localparam int NBX_W  = (CFG_W > MAXB_W) ? CFG_W : MAXB_W;
	localparam int BKX_W  = BKT_W + BKT_OUT_W;
	localparam int SLX_W  = FILL_W + SLOT_OUT_W;

	// ---------------- configuration registers ----------------
	logic [MODE_W-1:0] mode_q;
	logic [CFG_W-1:0]  prime_q;
	logic [CFG_W-1:0]  buckets_q;
	logic [1:0]        reg_idx;
	logic              cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = paddr[PADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= HASH_MODE_RST;
			prime_q   <= PRIME_RST;
			buckets_q <= BUCKETS_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_HASH_MODE: mode_q    <= pwdata[MODE_W-1:0];
				REG_PRIME:     prime_q   <= pwdata[CFG_W-1:0];
				REG_BUCKETS:   buckets_q <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_HASH_MODE: prdata = PDATA_W'(mode_q);
			REG_PRIME:     prdata = PDATA_W'(prime_q);
			REG_BUCKETS:   prdata = PDATA_W'(buckets_q);
			default:       prdata = '0;
		endcase
	end

	// Effective bucket count: zero acts as one, clamp to the table size.
	// Effective prime: zero acts as one.
	logic [NBX_W-1:0] buckets_x;
	logic [CFG_W-1:0] nb_eff;
	logic [CFG_W-1:0] prime_eff;

	assign buckets_x = NBX_W'(buckets_q);

	always_comb begin
		if (buckets_q == '0) begin
			nb_eff = CFG_W'(1);
		end else if (buckets_x > NBX_W'(MAX_BUCKETS)) begin
			nb_eff = CFG_W'(MAX_BUCKETS);
		end else begin
			nb_eff = buckets_q;
		end
		prime_eff = (prime_q == '0) ? CFG_W'(1) : prime_q;
	end

	// ---------------- shared units ----------------
	rem_req_t rem_req;
	rem_rsp_t rem_rsp;
	logic     bcd_start;
	logic     bcd_done;
	bcd_t     digits;

	bhi_rem u_rem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (rem_req),
		.rsp    (rem_rsp)
	);

	bhi_bcd u_bcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (bcd_start),
		.key    (rec.record_key),
		.done   (bcd_done),
		.digits (digits)
	);

	// ---------------- fill memory and slot storage ----------------
	logic              fill_wr_en;
	logic [BKT_W-1:0]  fill_wr_addr;
	logic [FILL_W-1:0] fill_wr_data;
	logic              fill_rd_en;
	logic [FILL_W-1:0] fill_rd_data;
	logic              store_wr;

	state_t            state_q;
	state_t            state_d;
	logic [BKT_W-1:0]  clr_q;
	logic [KEY_W-1:0]  key_q;
	logic [PAY_W-1:0]  payload_q;
	logic [BKT_W-1:0]  home_q;
	logic [BKT_W-1:0]  bkt_q;
	logic [CFG_W-1:0]  probe_cnt_q;

	bhi_fill #(
		.DEPTH  (MAX_BUCKETS),
		.ADDR_W (BKT_W),
		.DATA_W (FILL_W)
	) u_fill (
		.clk     (clk),
		.wr_en   (fill_wr_en),
		.wr_addr (fill_wr_addr),
		.wr_data (fill_wr_data),
		.rd_en   (fill_rd_en),
		.rd_addr (bkt_q),
		.rd_data (fill_rd_data)
	);

	bhi_store #(
		.SLOTS_PER_BUCKET (SLOTS_PER_BUCKET),
		.MAX_BUCKETS      (MAX_BUCKETS),
		.BKT_W            (BKT_W),
		.FILL_W           (FILL_W)
	) u_store (
		.clk     (clk),
		.wr_en   (store_wr),
		.bkt     (bkt_q),
		.slot    (fill_rd_data),
		.key     (key_q),
		.payload (payload_q)
	);

	// ---------------- sequencer ----------------
	logic             accept;
	logic             zero_key;
	logic             home_big;
	logic             hit;
	logic             last_probe;
	logic [CFG_W-1:0] bkt_inc;
	logic [BKT_W-1:0] bkt_nx;
	logic             res_valid_q;
	logic             out_load;

	assign rec.ready  = (state_q == ST_IDLE);
	assign accept     = rec.valid && rec.ready;
	assign zero_key   = (rec.record_key == '0);
	assign home_big   = (rem_rsp.rem >= nb_eff);
	assign hit        = (fill_rd_data < FILL_W'(SLOTS_PER_BUCKET));
	assign last_probe = ((probe_cnt_q + CFG_W'(1)) == nb_eff);
	assign bkt_inc    = CFG_W'(bkt_q) + CFG_W'(1);
	assign bkt_nx     = (bkt_inc == nb_eff) ? '0 : BKT_W'(bkt_inc);
	assign out_load   = (state_q == ST_OUT) && (!res_valid_q || res.ready);

	always_comb begin
		state_d      = state_q;
		rem_req      = '0;
		bcd_start    = 1'b0;
		fill_rd_en   = 1'b0;
		fill_wr_en   = 1'b0;
		fill_wr_addr = bkt_q;
		fill_wr_data = fill_rd_data + FILL_W'(1);
		store_wr     = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				// Sweep the fill memory back to empty, one bucket a cycle
				fill_wr_en   = 1'b1;
				fill_wr_addr = clr_q;
				fill_wr_data = '0;
				if (clr_q == BKT_W'(MAX_BUCKETS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					if (zero_key) begin
						state_d = ST_OUT;
					end else if (mode_q == MODE_PRIME) begin
						rem_req = '{start: 1'b1, len: LEN_W'(KEY_W),
							dividend: rec.record_key, divisor: prime_eff};
						state_d = ST_HASH;
					end else begin
						bcd_start = 1'b1;
						state_d   = ST_BCD;
					end
				end
			end
			ST_BCD: begin
				if (bcd_done) begin
					if (mode_q == MODE_FOLD) begin
						rem_req = '{start: 1'b1, len: LEN_W'(FOLD_W),
							dividend: DIV_W'(fold_sum(digits)), divisor: nb_eff};
					end else begin
						rem_req = '{start: 1'b1, len: LEN_W'(OCT_W),
							dividend: DIV_W'(octal_acc(digits)), divisor: prime_eff};
					end
					state_d = ST_HASH;
				end
			end
			ST_HASH: begin
				if (rem_rsp.done) begin
					if (home_big) begin
						// Remainder at or above the bucket count: fold back into range
						rem_req = '{start: 1'b1, len: LEN_W'(CFG_W),
							dividend: DIV_W'(rem_rsp.rem), divisor: nb_eff};
						state_d = ST_REDUCE;
					end else begin
						state_d = ST_RD;
					end
				end
			end
			ST_REDUCE: begin
				if (rem_rsp.done) begin
					state_d = ST_RD;
				end
			end
			ST_RD: begin
				fill_rd_en = 1'b1;
				state_d    = ST_CHK;
			end
			ST_CHK: begin
				if (hit) begin
					fill_wr_en = 1'b1;
					store_wr   = 1'b1;
					state_d    = ST_OUT;
				end else if (last_probe) begin
					state_d = ST_OUT;
				end else begin
					state_d = ST_RD;
				end
			end
			ST_OUT: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + BKT_W'(1);
			end
		end
	end

	// ---------------- datapath ----------------
	status_t           rstat_q;
	logic [BKT_W-1:0]  rhome_q;
	logic [BKT_W-1:0]  rplaced_q;
	logic [FILL_W-1:0] rslot_q;
	logic              rovf_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q     <= rec.record_key;
			payload_q <= rec.record_payload;
			// Zero key: reject with every other field cleared
			rstat_q   <= STAT_ZERO_KEY;
			rhome_q   <= '0;
			rplaced_q <= '0;
			rslot_q   <= '0;
			rovf_q    <= 1'b0;
		end
		if ((state_q == ST_HASH && rem_rsp.done && !home_big)
			|| (state_q == ST_REDUCE && rem_rsp.done)) begin
			home_q      <= BKT_W'(rem_rsp.rem);
			bkt_q       <= BKT_W'(rem_rsp.rem);
			probe_cnt_q <= '0;
		end
		if (state_q == ST_CHK) begin
			if (hit) begin
				rstat_q   <= STAT_STORED;
				rhome_q   <= home_q;
				rplaced_q <= bkt_q;
				rslot_q   <= fill_rd_data;
				rovf_q    <= (bkt_q != home_q);
			end else if (last_probe) begin
				// Every bucket in use is full: report home only
				rstat_q   <= STAT_FULL;
				rhome_q   <= home_q;
				rplaced_q <= '0;
				rslot_q   <= '0;
				rovf_q    <= 1'b0;
			end else begin
				// Advance to the next bucket, wrap at the bucket count
				bkt_q       <= bkt_nx;
				probe_cnt_q <= probe_cnt_q + CFG_W'(1);
			end
		end
	end

	// ---------------- result register ----------------
	status_t               res_stat_q;
	logic [BKT_OUT_W-1:0]  res_home_q;
	logic [BKT_OUT_W-1:0]  res_placed_q;
	logic [SLOT_OUT_W-1:0] res_slot_q;
	logic                  res_ovf_q;
	logic [BKX_W-1:0]      rhome_x;
	logic [BKX_W-1:0]      rplaced_x;
	logic [SLX_W-1:0]      rslot_x;

	assign rhome_x   = BKX_W'(rhome_q);
	assign rplaced_x = BKX_W'(rplaced_q);
	assign rslot_x   = SLX_W'(rslot_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_load) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			res_stat_q   <= rstat_q;
			res_home_q   <= rhome_x[BKT_OUT_W-1:0];
			res_placed_q <= rplaced_x[BKT_OUT_W-1:0];
			res_slot_q   <= rslot_x[SLOT_OUT_W-1:0];
			res_ovf_q    <= rovf_q;
		end
	end

	assign res.valid         = res_valid_q;
	assign res.status        = res_stat_q;
	assign res.home_bucket   = res_home_q;
	assign res.placed_bucket = res_placed_q;
	assign res.placed_slot   = res_slot_q;
	assign res.overflowed    = res_ovf_q;

	// ---------------- assertions ----------------
	a_zero_key_direct: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && zero_key) |=> (state_q == ST_OUT))
		else $error("zero key did not go straight to the result");

	a_rem_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		rem_rsp.done |-> (state_q == ST_HASH || state_q == ST_REDUCE))
		else $error("remainder finished outside a hash step");

	a_placed_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHK) |-> (CFG_W'(bkt_q) < nb_eff && CFG_W'(home_q) < nb_eff))
		else $error("probe bucket beyond the bucket count");

	a_store_fill_space: assert property (@(posedge clk) disable iff (!arst_n)
		store_wr |-> (state_q == ST_CHK && fill_wr_addr == bkt_q))
		else $error("slot write without a matching fill update");

endmodule
